// File: rtl/ethip_pkg.sv
// Shared types and constants for the Ethernet/IPv4 header parser.
// Holds beat and record structs, frame class codes and header offsets.
// No dependencies.
package ethip_pkg;

    localparam int POS_W = 16;
    localparam int L4_W  = 7;

    // EtherType and IPv4 protocol numbers
    localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
    localparam logic [15:0] ETYPE_ARP   = 16'h0806;
    localparam logic [15:0] ETYPE_IPV6  = 16'h86DD;
    localparam logic [7:0]  PROTO_ICMP  = 8'd1;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [7:0]  IHL_MASK    = 8'h0F;
    localparam logic [7:0]  TCP_FLAG_MASK = 8'h3F;

    // Byte positions in the frame
    localparam logic [POS_W-1:0] POS_DMAC     = 16'd0;
    localparam logic [POS_W-1:0] POS_SMAC     = 16'd6;
    localparam logic [POS_W-1:0] POS_ETYPE    = 16'd12;
    localparam logic [POS_W-1:0] POS_IHL      = 16'd14;
    localparam logic [POS_W-1:0] POS_PROTO    = 16'd23;
    localparam logic [POS_W-1:0] POS_SIP      = 16'd26;
    localparam logic [POS_W-1:0] POS_DIP      = 16'd30;
    // Last positions that must be present (captured length minus one)
    localparam logic [POS_W-1:0] POS_ETH_END  = 16'd13;
    localparam logic [POS_W-1:0] POS_IPV4_END = 16'd33;
    localparam logic [L4_W-1:0]  L4_BASE      = 7'd14;
    localparam logic [L4_W-1:0]  TCP_END_OFS  = 7'd19;
    localparam logic [L4_W-1:0]  UDP_END_OFS  = 7'd7;
    localparam logic [L4_W-1:0]  TCP_FLAG_OFS = 7'd13;

    typedef enum logic [2:0] {
        CLASS_TRUNC = 3'd0,
        CLASS_TCP   = 3'd1,
        CLASS_UDP   = 3'd2,
        CLASS_ICMP  = 3'd3,
        CLASS_IPV4  = 3'd4,
        CLASS_ARP   = 3'd5,
        CLASS_IPV6  = 3'd6,
        CLASS_OTHER = 3'd7
    } frame_class_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] wire_length;
    } beat_t;

    typedef struct packed {
        frame_class_t frame_class;
        logic [31:0]  frame_number;
        logic [47:0]  dest_mac;
        logic [47:0]  source_mac;
        logic [15:0]  ether_type;
        logic [31:0]  source_ip;
        logic [31:0]  dest_ip;
        logic [7:0]   ip_protocol;
        logic [15:0]  source_port;
        logic [15:0]  dest_port;
        logic [5:0]   tcp_flag_bits;
        logic [15:0]  frame_wire_length;
    } record_t;

    // Header fields picked off the byte stream as they pass
    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [15:0] ether_type;
        logic [3:0]  ihl;
        logic [7:0]  ip_protocol;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [5:0]  tcp_flags;
    } hdr_fields_t;

    // Layer-4 header offset: 14 + 4 * IHL, IHL taken as given
    function automatic logic [L4_W-1:0] l4_offset(input logic [3:0] ihl);
        return L4_BASE + {1'b0, ihl, 2'b00};
    endfunction

endpackage

// File: rtl/ethernet_ip_header_parser_unit.sv
// Top level of the Ethernet/IPv4/TCP/UDP header parser.
// Depends on ethip_pkg and ethip_hdr_capture.
//
// Byte channel (byte_valid, byte_stall, byte_data): one frame byte per beat in
//   wire order. last_byte marks the final captured byte, and wire_length is
//   sampled on that beat. A beat moves on a rising edge with valid high and
//   stall low.
// Record channel (rec_valid, rec_stall, rec_data): one record per frame that
//   ends while capture is enabled. Frames ending with capture off leave no
//   record and do not advance the frame number.
// Config channel (cfg_valid, cfg_ready, cfg_data): writes capture_enable;
//   cfg_ready is always high.
// Timing: header fields are picked off as bytes pass. A frame is classified in
//   the cycle its last byte is taken, and its record shows on rec_data the next cycle when the
//   output register is not stalled, else it waits in skid. One beat is taken every cycle while byte_stall is low.
// Stall: the output register plus one skid register take records while the
//   receiver stalls. byte_stall is high exactly while the skid register holds
//   a record, and drops in the cycle after it drains.
// Reset: rst_n clears the byte position, frame counter, capture_enable and both
//   record slots. Bytes are taken from the first cycle after reset.
module ethernet_ip_header_parser_unit
    import ethip_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    byte_valid,
    output logic    byte_stall,
    input  beat_t   byte_data,
    output logic    rec_valid,
    input  logic    rec_stall,
    output record_t rec_data,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  logic    cfg_data
);

    logic             beat_accept;
    logic [POS_W-1:0] pos;
    hdr_fields_t      hdr;

    logic             capture_en_reg;
    logic [31:0]      frame_counter_reg;
    logic             rec_new;
    record_t          rec_next;

    logic             out_valid_reg;
    record_t          out_data_reg;
    logic             skid_valid_reg;
    record_t          skid_data_reg;

    assign beat_accept = byte_valid && !byte_stall;
    assign byte_stall  = skid_valid_reg;
    assign cfg_ready   = 1'b1;

    ethip_hdr_capture u_capture (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat_accept (beat_accept),
        .beat        (byte_data),
        .pos         (pos),
        .hdr         (hdr)
    );

    // A record comes out of every accepted last byte while capture is on
    assign rec_new = beat_accept && byte_data.last_byte && capture_en_reg;

    // Classify from the merged header view; fields that do not apply stay zero
    always_comb
    begin
        logic [L4_W-1:0]  l4;
        logic [POS_W-1:0] tcp_end;
        logic [POS_W-1:0] udp_end;
        l4      = l4_offset(hdr.ihl);
        tcp_end = {{(POS_W-L4_W){1'b0}}, l4 + TCP_END_OFS};
        udp_end = {{(POS_W-L4_W){1'b0}}, l4 + UDP_END_OFS};

        rec_next                   = '0;
        rec_next.frame_class       = CLASS_TRUNC;
        rec_next.frame_number      = frame_counter_reg + 32'd1;
        rec_next.frame_wire_length = byte_data.wire_length;

        if (pos >= POS_ETH_END)
        begin
            rec_next.dest_mac   = hdr.dest_mac;
            rec_next.source_mac = hdr.source_mac;
            rec_next.ether_type = hdr.ether_type;
            if (hdr.ether_type == ETYPE_IPV4 && pos >= POS_IPV4_END)
            begin
                rec_next.source_ip   = hdr.source_ip;
                rec_next.dest_ip     = hdr.dest_ip;
                rec_next.ip_protocol = hdr.ip_protocol;
                if (hdr.ip_protocol == PROTO_TCP && pos >= tcp_end)
                begin
                    rec_next.frame_class   = CLASS_TCP;
                    rec_next.source_port   = hdr.source_port;
                    rec_next.dest_port     = hdr.dest_port;
                    rec_next.tcp_flag_bits = hdr.tcp_flags;
                end
                else if (hdr.ip_protocol == PROTO_UDP && pos >= udp_end)
                begin
                    rec_next.frame_class = CLASS_UDP;
                    rec_next.source_port = hdr.source_port;
                    rec_next.dest_port   = hdr.dest_port;
                end
                else if (hdr.ip_protocol == PROTO_ICMP)
                begin
                    rec_next.frame_class = CLASS_ICMP;
                end
                else
                begin
                    rec_next.frame_class = CLASS_IPV4;
                end
            end
            else if (hdr.ether_type == ETYPE_ARP)
            begin
                rec_next.frame_class = CLASS_ARP;
            end
            else if (hdr.ether_type == ETYPE_IPV6)
            begin
                rec_next.frame_class = CLASS_IPV6;
            end
            else
            begin
                rec_next.frame_class = CLASS_OTHER;
            end
        end
    end

    // Capture enable register and frame counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_en_reg    <= 1'b0;
            frame_counter_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capture_en_reg <= cfg_data;
            end
            if (rec_new)
            begin
                frame_counter_reg <= frame_counter_reg + 32'd1;
            end
        end
    end

    // Output register with skid: drain skid first, else load the new record;
    // hold a new record in skid while the output beat is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !rec_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= rec_new;
            end
        end
        else if (rec_new)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !rec_stall)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (rec_new)
            begin
                out_data_reg <= rec_next;
            end
        end
        else if (rec_new)
        begin
            skid_data_reg <= rec_next;
        end
    end

    assign rec_valid = out_valid_reg;
    assign rec_data  = out_data_reg;

    // Skid never holds a record without one waiting in the output register
    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // No new record may arrive while the skid register is occupied
    a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !rec_new)
        else $error("record produced with skid register full");

    // Counter advances by one exactly when a record is produced
    a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
        rec_new |=> frame_counter_reg == $past(frame_counter_reg) + 32'd1)
        else $error("frame counter did not advance on a record");

    // Truncated frames carry no addresses or EtherType
    a_trunc_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.frame_class == CLASS_TRUNC) |->
        (out_data_reg.dest_mac == '0 && out_data_reg.source_mac == '0 &&
         out_data_reg.ether_type == '0))
        else $error("truncated record carries header fields");

    // Ports only for TCP and UDP records
    a_ports_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.frame_class != CLASS_TCP &&
         out_data_reg.frame_class != CLASS_UDP) |->
        (out_data_reg.source_port == '0 && out_data_reg.dest_port == '0 &&
         out_data_reg.tcp_flag_bits == '0))
        else $error("port fields set on a non TCP/UDP record");

endmodule

// File: rtl/ethip_hdr_capture.sv
// Byte position counter and on-the-fly header field capture.
// Depends on ethip_pkg.
module ethip_hdr_capture
    import ethip_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                beat_accept,
    input  beat_t               beat,
    output logic [POS_W-1:0]    pos,
    output hdr_fields_t         hdr
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    hdr_fields_t      hdr_reg;
    hdr_fields_t      hdr_next;

    // Merge the current byte into whichever field its position belongs to
    always_comb
    begin
        logic [L4_W-1:0]  l4;
        logic [POS_W-1:0] l4_pos;
        hdr_next = hdr_reg;
        for (int i = 0; i < 6; i++)
        begin
            if (pos_reg == POS_DMAC + POS_W'(i))
            begin
                hdr_next.dest_mac[8*(5-i) +: 8] = beat.data_byte;
            end
            if (pos_reg == POS_SMAC + POS_W'(i))
            begin
                hdr_next.source_mac[8*(5-i) +: 8] = beat.data_byte;
            end
        end
        for (int i = 0; i < 2; i++)
        begin
            if (pos_reg == POS_ETYPE + POS_W'(i))
            begin
                hdr_next.ether_type[8*(1-i) +: 8] = beat.data_byte;
            end
        end
        if (pos_reg == POS_IHL)
        begin
            hdr_next.ihl = beat.data_byte[3:0];
        end
        if (pos_reg == POS_PROTO)
        begin
            hdr_next.ip_protocol = beat.data_byte;
        end
        for (int i = 0; i < 4; i++)
        begin
            if (pos_reg == POS_SIP + POS_W'(i))
            begin
                hdr_next.source_ip[8*(3-i) +: 8] = beat.data_byte;
            end
            if (pos_reg == POS_DIP + POS_W'(i))
            begin
                hdr_next.dest_ip[8*(3-i) +: 8] = beat.data_byte;
            end
        end
        // IHL may arrive in this very beat, so use the merged value
        l4     = l4_offset(hdr_next.ihl);
        l4_pos = {{(POS_W-L4_W){1'b0}}, l4};
        for (int i = 0; i < 2; i++)
        begin
            if (pos_reg == l4_pos + POS_W'(i))
            begin
                hdr_next.source_port[8*(1-i) +: 8] = beat.data_byte;
            end
            if (pos_reg == l4_pos + POS_W'(i + 2))
            begin
                hdr_next.dest_port[8*(1-i) +: 8] = beat.data_byte;
            end
        end
        if (pos_reg == l4_pos + {{(POS_W-L4_W){1'b0}}, TCP_FLAG_OFS})
        begin
            hdr_next.tcp_flags = beat.data_byte[5:0];
        end
    end

    // Restart at the frame end, otherwise advance and saturate
    always_comb
    begin
        if (beat.last_byte)
        begin
            pos_next = '0;
        end
        else if (pos_reg != '1)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (beat_accept)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_accept)
        begin
            hdr_reg <= hdr_next;
        end
    end

    assign pos = pos_reg;
    assign hdr = hdr_next;

endmodule
